// File: rtl/cbf_pkg.sv
// Package for the cubic Bezier flattener: widths, controller states,
// controller/datapath command and status structs. No dependencies.
package cbf_pkg;

    localparam int COORD_W         = 32;
    localparam int TOL_W           = 16;
    localparam int TOL_FRAC_BITS   = 8;
    localparam int DEF_MAX_DEPTH   = 6;
    localparam int DEF_FRAC_BITS   = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DECIDE,
        ST_EMIT_MID,
        ST_POP,
        ST_EMIT_END
    } ctrl_state_t;

    typedef struct packed {
        logic load;       // take the input curve into cur
        logic mul_start;  // start the flatness evaluation
        logic split;      // replace cur by left half, push right half
        logic pop;        // load cur from top of stack
        logic mid_out;    // load output register with midpoint
        logic end_out;    // load output register with end point
    } dp_cmd_t;

    typedef struct packed {
        logic flat;
        logic eval_done;
        logic at_limit;
        logic stack_empty;
    } dp_status_t;

endpackage

// File: rtl/cbf_datapath.sv
// Datapath of the cubic Bezier flattener: current sub-curve, subdivision
// stack, sequential flatness evaluator and output register. Uses cbf_pkg.
module cbf_datapath #(
    parameter int MAX_DEPTH = cbf_pkg::DEF_MAX_DEPTH,
    parameter int FRAC_BITS = cbf_pkg::DEF_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [cbf_pkg::TOL_W-1:0]           flat_tolerance,
    input  cbf_pkg::dp_cmd_t                    cmd,
    output cbf_pkg::dp_status_t                 status,
    input  logic signed [cbf_pkg::COORD_W-1:0]  in_pts [8],
    output logic signed [cbf_pkg::COORD_W-1:0]  out_x,
    output logic signed [cbf_pkg::COORD_W-1:0]  out_y,
    output logic                                out_last
);
    import cbf_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int PW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int PRODW = 144;

    logic signed [COORD_W-1:0] cur_reg [8];
    logic signed [COORD_W-1:0] end_reg [2];
    logic [DW-1:0]             depth_reg;
    logic [DW-1:0]             sp_reg;
    logic signed [COORD_W-1:0] stk_mem [MAX_DEPTH][8];
    logic [DW-1:0]             lvl_mem [MAX_DEPTH];
    logic signed [COORD_W-1:0] out_x_reg;
    logic signed [COORD_W-1:0] out_y_reg;
    logic                      out_last_reg;

    // floor average of two coordinates
    function automatic logic signed [COORD_W-1:0] avg(
        input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return s[COORD_W:1];
    endfunction

    // de Casteljau halving, both axes
    logic signed [COORD_W-1:0] lft [8];
    logic signed [COORD_W-1:0] rgt [8];
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            logic signed [COORD_W-1:0] p01, p12, p23, p012, p123, m;
            p01  = avg(cur_reg[i], cur_reg[2+i]);
            p12  = avg(cur_reg[2+i], cur_reg[4+i]);
            p23  = avg(cur_reg[4+i], cur_reg[6+i]);
            p012 = avg(p01, p12);
            p123 = avg(p12, p23);
            m    = avg(p012, p123);
            lft[i] = cur_reg[i]; lft[2+i] = p01; lft[4+i] = p012; lft[6+i] = m;
            rgt[i] = m; rgt[2+i] = p123; rgt[4+i] = p23; rgt[6+i] = cur_reg[6+i];
        end
    end

    // Flatness evaluator: one product per step into a register
    // step 0: a1*dy 1: b1*dx 2: a2*dy 3: b2*dx 4: dx^2 5: dy^2
    // 6: s = d1 + d2, 7..9: s^2 in three partial products, 10: tol*q, 11: compare
    logic [3:0]               step_reg;
    logic                     busy_reg;
    logic signed [COORD_W:0]  dx_reg, dy_reg, a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [66:0]       prod_reg;
    logic signed [67:0]       c1_reg, c2_reg;
    logic [67:0]              q_reg;
    logic [68:0]              s_reg;
    logic [PRODW-1:0]         lhs_reg;
    logic [PRODW-1:0]         rhs_reg;
    logic                     flat_reg;
    logic                     done_reg;

    logic signed [COORD_W:0]  ma, mb;
    logic signed [66:0]       mp;
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (step_reg)
            4'd0:    begin ma = a1_reg; mb = dy_reg; end
            4'd1:    begin ma = b1_reg; mb = dx_reg; end
            4'd2:    begin ma = a2_reg; mb = dy_reg; end
            4'd3:    begin ma = b2_reg; mb = dx_reg; end
            4'd4:    begin ma = dx_reg; mb = dx_reg; end
            4'd5:    begin ma = dy_reg; mb = dy_reg; end
            default: begin ma = '0; mb = '0; end
        endcase
        mp = 67'(ma * mb);
    end

    // s^2 in partial products of 35-bit halves
    logic [34:0] s_lo, s_hi;
    logic [69:0] sp_prod;
    assign s_lo = s_reg[34:0];
    assign s_hi = {1'b0, s_reg[68:35]};
    always_comb
    begin
        case (step_reg)
            4'd7:    sp_prod = s_lo * s_lo;
            4'd8:    sp_prod = s_lo * s_hi;
            4'd9:    sp_prod = s_hi * s_hi;
            default: sp_prod = '0;
        endcase
    end

    logic [67:0] c1_abs, c2_abs;
    assign c1_abs = c1_reg[67] ? 68'(-c1_reg) : 68'(c1_reg);
    assign c2_abs = c2_reg[67] ? 68'(-c2_reg) : 68'(c2_reg);

    // run the evaluator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.mul_start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd11)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            dx_reg <= {cur_reg[6][COORD_W-1], cur_reg[6]} - {cur_reg[0][COORD_W-1], cur_reg[0]};
            dy_reg <= {cur_reg[7][COORD_W-1], cur_reg[7]} - {cur_reg[1][COORD_W-1], cur_reg[1]};
            a1_reg <= {cur_reg[2][COORD_W-1], cur_reg[2]} - {cur_reg[6][COORD_W-1], cur_reg[6]};
            b1_reg <= {cur_reg[3][COORD_W-1], cur_reg[3]} - {cur_reg[7][COORD_W-1], cur_reg[7]};
            a2_reg <= {cur_reg[4][COORD_W-1], cur_reg[4]} - {cur_reg[6][COORD_W-1], cur_reg[6]};
            b2_reg <= {cur_reg[5][COORD_W-1], cur_reg[5]} - {cur_reg[7][COORD_W-1], cur_reg[7]};
        end
        else if (busy_reg)
        begin
            prod_reg <= mp;
            case (step_reg)
                4'd1:  c1_reg <= 68'(prod_reg);
                4'd2:  c1_reg <= c1_reg - 68'(prod_reg);
                4'd3:  c2_reg <= 68'(prod_reg);
                4'd4:  c2_reg <= c2_reg - 68'(prod_reg);
                4'd5:  q_reg  <= 68'(prod_reg);
                4'd6:
                begin
                    q_reg <= q_reg + 68'(prod_reg);
                    s_reg <= {1'b0, c1_abs} + {1'b0, c2_abs};
                end
                4'd7:  lhs_reg <= PRODW'(sp_prod);
                4'd8:  lhs_reg <= lhs_reg + (PRODW'(sp_prod) << 36);
                4'd9:  lhs_reg <= (lhs_reg + (PRODW'(sp_prod) << 70)) << TOL_FRAC_BITS;
                4'd10: rhs_reg <= PRODW'(q_reg * flat_tolerance) << (2 * FRAC_BITS);
                4'd11: flat_reg <= lhs_reg < rhs_reg;
                default: ;
            endcase
        end
    end

    // current sub-curve, depth and stack
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg    <= '0;
            depth_reg <= '0;
        end
        else if (cmd.load)
        begin
            sp_reg    <= '0;
            depth_reg <= '0;
        end
        else if (cmd.split)
        begin
            if (sp_reg < DW'(MAX_DEPTH))
                sp_reg <= sp_reg + 1'b1;
            depth_reg <= depth_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            sp_reg    <= sp_reg - 1'b1;
            depth_reg <= lvl_mem[PW'(sp_reg - 1'b1)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg    <= in_pts;
            end_reg[0] <= in_pts[6];
            end_reg[1] <= in_pts[7];
        end
        else if (cmd.split)
        begin
            cur_reg <= lft;
            if (sp_reg < DW'(MAX_DEPTH))
            begin
                stk_mem[PW'(sp_reg)] <= rgt;
                lvl_mem[PW'(sp_reg)] <= depth_reg + 1'b1;
            end
        end
        else if (cmd.pop)
            cur_reg <= stk_mem[PW'(sp_reg - 1'b1)];
        if (cmd.mid_out)
        begin
            out_x_reg    <= lft[6];
            out_y_reg    <= lft[7];
            out_last_reg <= 1'b0;
        end
        else if (cmd.end_out)
        begin
            out_x_reg    <= end_reg[0];
            out_y_reg    <= end_reg[1];
            out_last_reg <= 1'b1;
        end
    end

    assign out_x    = out_x_reg;
    assign out_y    = out_y_reg;
    assign out_last = out_last_reg;

    assign status.flat        = flat_reg;
    assign status.eval_done   = done_reg;
    assign status.at_limit    = (depth_reg + 1'b1) >= DW'(MAX_DEPTH);
    assign status.stack_empty = (sp_reg == '0);

    // stack never overflows: depth bounds the pending halves
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= DW'(MAX_DEPTH)) else $error("stack pointer overflow");
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg < DW'(MAX_DEPTH)) else $error("depth beyond limit");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> sp_reg != '0) else $error("pop from empty stack");
endmodule

// File: rtl/cbf_ctrl.sv
// Controller of the cubic Bezier flattener: sequences evaluation, split,
// pop and output handshake. Uses cbf_pkg.
module cbf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cbf_pkg::dp_cmd_t     cmd,
    input  cbf_pkg::dp_status_t  status
);
    import cbf_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        ovalid_reg, ovalid_next;
    logic        out_free;

    assign out_free = !ovalid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_SETUP;
            ST_SETUP:    state_next = ST_MUL;
            ST_MUL:      if (status.eval_done) state_next = ST_DECIDE;
            ST_DECIDE:
                if (status.flat)          state_next = ST_EMIT_MID;
                else if (!status.at_limit) state_next = ST_SETUP;
                else if (status.stack_empty) state_next = ST_EMIT_END;
                else                      state_next = ST_POP;
            ST_EMIT_MID:
                if (out_free)
                    state_next = status.stack_empty ? ST_EMIT_END : ST_POP;
            ST_POP:      state_next = ST_SETUP;
            ST_EMIT_END: if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd         = '0;
        ovalid_next = ovalid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:   cmd.load = in_valid;
            ST_SETUP:  cmd.mul_start = 1'b1;
            ST_DECIDE: cmd.split = !status.flat && !status.at_limit;
            ST_EMIT_MID:
                if (out_free)
                begin
                    cmd.mid_out = 1'b1;
                    ovalid_next = 1'b1;
                end
            ST_POP:    cmd.pop = 1'b1;
            ST_EMIT_END:
                if (out_free)
                begin
                    cmd.end_out = 1'b1;
                    ovalid_next = 1'b1;
                end
            default: ;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul_start, cmd.split, cmd.pop, cmd.mid_out, cmd.end_out}))
        else $error("conflicting datapath commands");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && out_stall) |-> !(cmd.mid_out || cmd.end_out))
        else $error("output overwritten while stalled");
    a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        status.eval_done |-> state_reg == ST_MUL) else $error("stray evaluation done");
endmodule

// File: rtl/cubic_bezier_flattener.sv
// Cubic Bezier flattener: adaptive de Casteljau subdivision of one curve
// per transaction into polyline points. Uses cbf_pkg, cbf_ctrl, cbf_datapath.
//
// One curve is taken at a time; in_stall stays high until its end point has
// been handed to the output register. For each subdivision node, time-shared
// multipliers evaluate the flatness test in a dozen dependent steps, then a
// split, emit or pop step follows. A curve visits up to 2^MAX_DEPTH-1
// nodes; output stalls lengthen its processing. The user must write
// flat_tolerance through tol_we/tol_wdata only while the block is idle;
// the block itself does not enforce this.
module cubic_bezier_flattener #(
    parameter int MAX_DEPTH       = cbf_pkg::DEF_MAX_DEPTH,
    parameter int COORD_FRAC_BITS = cbf_pkg::DEF_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               tol_we,
    input  logic [cbf_pkg::TOL_W-1:0]          tol_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [cbf_pkg::COORD_W-1:0] start_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] start_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] ctrl1_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] ctrl1_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] ctrl2_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] ctrl2_y,
    input  logic signed [cbf_pkg::COORD_W-1:0] end_x,
    input  logic signed [cbf_pkg::COORD_W-1:0] end_y,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [cbf_pkg::COORD_W-1:0] point_x,
    output logic signed [cbf_pkg::COORD_W-1:0] point_y,
    output logic                               last_point
);
    import cbf_pkg::*;

    logic [TOL_W-1:0]          tol_reg;
    dp_cmd_t                   cmd;
    dp_status_t                status;
    logic signed [COORD_W-1:0] pts [8];

    // hold tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (tol_we)
            tol_reg <= tol_wdata;
    end

    assign pts[0] = start_x;
    assign pts[1] = start_y;
    assign pts[2] = ctrl1_x;
    assign pts[3] = ctrl1_y;
    assign pts[4] = ctrl2_x;
    assign pts[5] = ctrl2_y;
    assign pts[6] = end_x;
    assign pts[7] = end_y;

    cbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    cbf_datapath #(
        .MAX_DEPTH (MAX_DEPTH),
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .flat_tolerance (tol_reg),
        .cmd            (cmd),
        .status         (status),
        .in_pts         (pts),
        .out_x          (point_x),
        .out_y          (point_y),
        .out_last       (last_point)
    );
endmodule
